// ===== rtl/core/vtbc_pkg.sv =====
package vtbc_pkg;

   // Storage depth of the transformed vertex store.
   localparam int VERTEX_DEPTH_DEF = 4096;

   // Field widths.
   localparam int SLOT_W  = 12;
   localparam int POS_W   = 16;
   localparam int NDC_W   = 16;
   localparam int COEF_W  = 16;
   localparam int CLIP_W  = 34;
   localparam int QUOT_W  = 16;
   localparam int REM_W   = 48;

   // Queue depths.
   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH       = 32;

   // Saturation limits of a Q2.14 value.
   localparam logic [NDC_W-1:0] NDC_MAX = 16'h7FFF;
   localparam logic [NDC_W-1:0] NDC_MIN = 16'h8000;

   // Register reset values.
   localparam logic [12:0] HALF_WIDTH_RST  = 13'd320;
   localparam logic [12:0] HALF_HEIGHT_RST = 13'd240;
   localparam logic [30:0] DEPTH_SCALE_RST = 31'd100000000;

   typedef enum logic {
      OP_VERTEX   = 1'b0,
      OP_TRIANGLE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      CSR_ROW0        = 3'd0,
      CSR_ROW1        = 3'd1,
      CSR_ROW2        = 3'd2,
      CSR_ROW3        = 3'd3,
      CSR_HALF_WIDTH  = 3'd4,
      CSR_HALF_HEIGHT = 3'd5,
      CSR_DEPTH_SCALE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [3:0][63:0] row;
      logic [12:0]      half_width;
      logic [12:0]      half_height;
      logic [30:0]      depth_scale;
   } cfg_type;

   typedef struct packed {
      op_type                 op;
      logic [SLOT_W-1:0]      vertex_slot;
      logic [POS_W-1:0]       pos_x;
      logic [POS_W-1:0]       pos_y;
      logic [POS_W-1:0]       pos_z;
      logic [2:0][SLOT_W-1:0] corner;
      logic                   slot_ok;
      logic [2:0]             corner_ok;
   } cmd_type;

   typedef struct packed {
      logic [15:0] screen_x;
      logic [15:0] screen_y;
      logic [31:0] screen_z;
      logic        draw_triangle;
      logic        range_fault;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } result_push_type;

endpackage

// ===== rtl/core/vtbc_channels.sv =====
interface vtbc_req_if import vtbc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [SLOT_W-1:0]        vertex_slot;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic signed [POS_W-1:0]  pos_z;
   logic [SLOT_W-1:0]        corner_a;
   logic [SLOT_W-1:0]        corner_b;
   logic [SLOT_W-1:0]        corner_c;

   modport source (output valid, op, vertex_slot, pos_x, pos_y, pos_z,
                   corner_a, corner_b, corner_c, input ready);
   modport sink (input valid, op, vertex_slot, pos_x, pos_y, pos_z,
                 corner_a, corner_b, corner_c, output ready);
endinterface

interface vtbc_rsp_if import vtbc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [15:0] screen_x;
   logic signed [15:0] screen_y;
   logic signed [31:0] screen_z;
   logic               draw_triangle;
   logic               range_fault;

   modport source (output valid, screen_x, screen_y, screen_z, draw_triangle,
                   range_fault, input ready);
   modport sink (input valid, screen_x, screen_y, screen_z, draw_triangle,
                 range_fault, output ready);
endinterface

interface vtbc_csr_if import vtbc_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/vtbc_front.sv =====
module vtbc_front import vtbc_pkg::*; #(
   parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   vtbc_req_if.sink req,
   output logic     cmd_valid,
   output cmd_type  cmd,
   input  logic     cmd_ready
);

   localparam int QAW = $clog2(CMD_QUEUE_DEPTH);

   cmd_type        queue_ff [CMD_QUEUE_DEPTH];
   logic [QAW-1:0] wr_ptr_ff;
   logic [QAW-1:0] rd_ptr_ff;
   logic [QAW:0]   count_ff;
   cmd_type        class_in;
   logic           push;
   logic           pop;

   // Classify the incoming item and check its indices against the store depth.
   always_comb begin
      class_in.op          = op_type'(req.op);
      class_in.vertex_slot = req.vertex_slot;
      class_in.pos_x       = req.pos_x;
      class_in.pos_y       = req.pos_y;
      class_in.pos_z       = req.pos_z;
      class_in.corner[0]   = req.corner_a;
      class_in.corner[1]   = req.corner_b;
      class_in.corner[2]   = req.corner_c;
      class_in.slot_ok     = 32'(req.vertex_slot) < 32'(VERTEX_DEPTH);
      class_in.corner_ok[0] = 32'(req.corner_a) < 32'(VERTEX_DEPTH);
      class_in.corner_ok[1] = 32'(req.corner_b) < 32'(VERTEX_DEPTH);
      class_in.corner_ok[2] = 32'(req.corner_c) < 32'(VERTEX_DEPTH);
   end

   assign req.ready = count_ff != (QAW+1)'(CMD_QUEUE_DEPTH);
   assign push      = req.valid && req.ready;
   assign cmd_valid = count_ff != '0;
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = queue_ff[rd_ptr_ff];

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= class_in;
      end
   end

   // Queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/core/vtbc_back.sv =====
module vtbc_back import vtbc_pkg::*; #(
   parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            in_valid,
   input  cmd_type         in_cmd,
   output result_push_type out_push
);

   localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

   typedef struct packed {
      op_type             op;
      logic [AW-1:0]      slot;
      logic               slot_ok;
      logic [2:0][AW-1:0] corner;
      logic [2:0]         corner_ok;
   } tag_type;

   typedef struct packed {
      logic [2:0][REM_W-1:0]  rem;
      logic [2:0][QUOT_W-1:0] quot;
      logic [2:0]             big;
      logic [2:0]             neg;
      logic [31:0]            w;
      logic                   w_pos;
      tag_type                tag;
   } div_type;

   // Truncate a Q.14 product toward zero and saturate it to 16 bits; flag on top.
   function automatic logic [16:0] shrink16(input logic [30:0] v);
      logic [30:0] mag;
      logic [16:0] sh;
      logic [16:0] res;
      mag = v[30] ? (31'd0 - v) : v;
      sh  = mag[30:14];
      if (!v[30]) begin
         res = (sh > 17'd32767) ? {1'b1, 16'h7FFF} : {1'b0, sh[15:0]};
      end else begin
         res = (sh > 17'd32768) ? {1'b1, 16'h8000} : {1'b0, 16'd0 - sh[15:0]};
      end
      return res;
   endfunction

   // The same for the 32-bit depth output.
   function automatic logic [32:0] shrink32(input logic [47:0] v);
      logic [47:0] mag;
      logic [33:0] sh;
      logic [32:0] res;
      mag = v[47] ? (48'd0 - v) : v;
      sh  = mag[47:14];
      if (!v[47]) begin
         res = (sh > 34'h07FFFFFFF) ? {1'b1, 32'h7FFFFFFF} : {1'b0, sh[31:0]};
      end else begin
         res = (sh > 34'h080000000) ? {1'b1, 32'h80000000}
                                    : {1'b0, 32'd0 - sh[31:0]};
      end
      return res;
   endfunction

   // Stage 1: twelve coefficient products.
   logic                         s1_valid_ff;
   tag_type                      s1_tag_ff;
   logic [3:0][2:0][31:0]        s1_prod_ff;
   logic [3:0][COEF_W-1:0]       s1_coef_ff;
   logic [3:0][2:0][31:0]        s1_prod_in;
   logic [2:0][POS_W-1:0]        pos_vec;
   tag_type                      s1_tag_in;

   assign pos_vec = {in_cmd.pos_z, in_cmd.pos_y, in_cmd.pos_x};

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 3; k++) begin
            s1_prod_in[r][k] = $signed(cfg.row[r][COEF_W*k +: COEF_W])
                             * $signed(pos_vec[k]);
         end
      end
      s1_tag_in.op        = in_cmd.op;
      s1_tag_in.slot      = AW'(in_cmd.vertex_slot);
      s1_tag_in.slot_ok   = in_cmd.slot_ok;
      for (int k = 0; k < 3; k++) begin
         s1_tag_in.corner[k] = AW'(in_cmd.corner[k]);
      end
      s1_tag_in.corner_ok = in_cmd.corner_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_prod_ff <= s1_prod_in;
      s1_tag_ff  <= s1_tag_in;
      for (int r = 0; r < 4; r++) begin
         s1_coef_ff[r] <= cfg.row[r][3*COEF_W +: COEF_W];
      end
   end

   // Stage 2: sum each row into a clip coordinate with 20 fraction bits.
   logic                    s2_valid_ff;
   tag_type                 s2_tag_ff;
   logic [3:0][CLIP_W-1:0]  s2_clip_ff;
   logic [3:0][CLIP_W-1:0]  s2_clip_in;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         s2_clip_in[r] = CLIP_W'($signed(s1_prod_ff[r][0]))
                       + CLIP_W'($signed(s1_prod_ff[r][1]))
                       + CLIP_W'($signed(s1_prod_ff[r][2]))
                       + CLIP_W'($signed({s1_coef_ff[r], 8'd0}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_clip_ff <= s2_clip_in;
      s2_tag_ff  <= s1_tag_ff;
   end

   // Stage 3: magnitudes, w check and the overflow test ahead of the divider.
   div_type                div_ff [0:QUOT_W];
   logic [QUOT_W:0]        div_valid_ff;
   div_type                div_first_in;

   always_comb begin
      logic [CLIP_W-1:0] mag;
      logic [REM_W-1:0]  num;
      logic [REM_W-1:0]  lim;
      div_first_in.w     = s2_clip_ff[3][31:0];
      div_first_in.w_pos = !s2_clip_ff[3][CLIP_W-1] && (s2_clip_ff[3] != '0);
      div_first_in.tag   = s2_tag_ff;
      lim = REM_W'(s2_clip_ff[3][31:0]) << QUOT_W;
      for (int k = 0; k < 3; k++) begin
         div_first_in.neg[k]  = s2_clip_ff[k][CLIP_W-1];
         mag = s2_clip_ff[k][CLIP_W-1] ? (CLIP_W'(0) - s2_clip_ff[k]) : s2_clip_ff[k];
         num = REM_W'({mag[31:0], 14'd0});
         div_first_in.big[k]  = num >= lim;
         div_first_in.rem[k]  = num;
         div_first_in.quot[k] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff <= '0;
      end else begin
         div_valid_ff <= {div_valid_ff[QUOT_W-1:0], s2_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      div_ff[0] <= div_first_in;
   end

   // Restoring divider, one quotient bit per stage for all three lanes.
   for (genvar j = 1; j <= QUOT_W; j++) begin : g_div
      localparam int BIT = QUOT_W - j;
      div_type div_in;

      always_comb begin
         logic [REM_W-1:0] wsh;
         div_in = div_ff[j-1];
         wsh    = REM_W'(div_ff[j-1].w) << BIT;
         for (int k = 0; k < 3; k++) begin
            if (div_ff[j-1].rem[k] >= wsh) begin
               div_in.rem[k]       = div_ff[j-1].rem[k] - wsh;
               div_in.quot[k][BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         div_ff[j] <= div_in;
      end
   end

   // Stage 4: signed and saturated normalized coordinates.
   logic                   s4_valid_ff;
   tag_type                s4_tag_ff;
   logic [2:0][NDC_W-1:0]  s4_ndc_ff;
   logic                   s4_fault_ff;
   logic [2:0][NDC_W-1:0]  s4_ndc_in;
   logic                   s4_fault_in;

   always_comb begin
      logic [QUOT_W-1:0] q;
      s4_fault_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         q = div_ff[QUOT_W].quot[k];
         if (!div_ff[QUOT_W].w_pos) begin
            s4_ndc_in[k] = '0;
            s4_fault_in  = 1'b1;
         end else if (div_ff[QUOT_W].big[k]) begin
            s4_ndc_in[k] = div_ff[QUOT_W].neg[k] ? NDC_MIN : NDC_MAX;
            s4_fault_in  = 1'b1;
         end else if (!div_ff[QUOT_W].neg[k]) begin
            if (q > NDC_MAX) begin
               s4_ndc_in[k] = NDC_MAX;
               s4_fault_in  = 1'b1;
            end else begin
               s4_ndc_in[k] = q;
            end
         end else begin
            if (q > NDC_MIN) begin
               s4_ndc_in[k] = NDC_MIN;
               s4_fault_in  = 1'b1;
            end else begin
               s4_ndc_in[k] = NDC_W'(0) - q;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= div_valid_ff[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      s4_ndc_ff   <= s4_ndc_in;
      s4_fault_ff <= s4_fault_in;
      s4_tag_ff   <= div_ff[QUOT_W].tag;
   end

   // Vertex store: three copies, one read port each for the triangle corners.
   logic [2*NDC_W-1:0] store_a [VERTEX_DEPTH];
   logic [2*NDC_W-1:0] store_b [VERTEX_DEPTH];
   logic [2*NDC_W-1:0] store_c [VERTEX_DEPTH];
   logic [2*NDC_W-1:0] rd_a_ff;
   logic [2*NDC_W-1:0] rd_b_ff;
   logic [2*NDC_W-1:0] rd_c_ff;
   logic               store_we;

   assign store_we = s4_valid_ff && (s4_tag_ff.op == OP_VERTEX) && s4_tag_ff.slot_ok;

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_a[s4_tag_ff.slot] <= {s4_ndc_ff[1], s4_ndc_ff[0]};
         store_b[s4_tag_ff.slot] <= {s4_ndc_ff[1], s4_ndc_ff[0]};
         store_c[s4_tag_ff.slot] <= {s4_ndc_ff[1], s4_ndc_ff[0]};
      end
      rd_a_ff <= store_a[s4_tag_ff.corner[0]];
      rd_b_ff <= store_b[s4_tag_ff.corner[1]];
      rd_c_ff <= store_c[s4_tag_ff.corner[2]];
   end

   // Stage 5: screen scaling products.
   logic               s5_valid_ff;
   tag_type            s5_tag_ff;
   logic               s5_fault_ff;
   logic [30:0]        s5_px_ff;
   logic [30:0]        s5_py_ff;
   logic [47:0]        s5_pz_ff;
   logic [30:0]        s5_px_in;
   logic [30:0]        s5_py_in;
   logic [47:0]        s5_pz_in;

   always_comb begin
      logic signed [16:0] bx;
      logic signed [16:0] by;
      bx = 17'($signed(s4_ndc_ff[0])) + 17'sd16384;
      by = 17'($signed(s4_ndc_ff[1])) + 17'sd16384;
      s5_px_in = $signed({1'b0, cfg.half_width}) * bx;
      s5_py_in = $signed({1'b0, cfg.half_height}) * by;
      s5_pz_in = $signed({1'b0, cfg.depth_scale}) * $signed(s4_ndc_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_px_ff    <= s5_px_in;
      s5_py_ff    <= s5_py_in;
      s5_pz_ff    <= s5_pz_in;
      s5_fault_ff <= s4_fault_ff;
      s5_tag_ff   <= s4_tag_ff;
   end

   // Stage 6: truncate and saturate screen values; form corner differences.
   logic               s6_valid_ff;
   op_type             s6_op_ff;
   logic [15:0]        s6_sx_ff;
   logic [15:0]        s6_sy_ff;
   logic [31:0]        s6_sz_ff;
   logic               s6_fault_ff;
   logic [3:0][16:0]   s6_diff_ff;
   logic [16:0]        s6_x_in;
   logic [16:0]        s6_y_in;
   logic [32:0]        s6_z_in;
   logic [3:0][16:0]   s6_diff_in;

   always_comb begin
      logic [2:0][15:0] cx;
      logic [2:0][15:0] cy;
      s6_x_in = shrink16(s5_px_ff);
      s6_y_in = shrink16(s5_py_ff);
      s6_z_in = shrink32(s5_pz_ff);
      cx[0] = s5_tag_ff.corner_ok[0] ? rd_a_ff[15:0]  : 16'd0;
      cy[0] = s5_tag_ff.corner_ok[0] ? rd_a_ff[31:16] : 16'd0;
      cx[1] = s5_tag_ff.corner_ok[1] ? rd_b_ff[15:0]  : 16'd0;
      cy[1] = s5_tag_ff.corner_ok[1] ? rd_b_ff[31:16] : 16'd0;
      cx[2] = s5_tag_ff.corner_ok[2] ? rd_c_ff[15:0]  : 16'd0;
      cy[2] = s5_tag_ff.corner_ok[2] ? rd_c_ff[31:16] : 16'd0;
      // Edge vectors from the first corner.
      s6_diff_in[0] = 17'($signed(cx[1])) - 17'($signed(cx[0]));
      s6_diff_in[1] = 17'($signed(cy[2])) - 17'($signed(cy[0]));
      s6_diff_in[2] = 17'($signed(cx[2])) - 17'($signed(cx[0]));
      s6_diff_in[3] = 17'($signed(cy[1])) - 17'($signed(cy[0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_op_ff    <= s5_tag_ff.op;
      s6_sx_ff    <= s6_x_in[15:0];
      s6_sy_ff    <= s6_y_in[15:0];
      s6_sz_ff    <= s6_z_in[31:0];
      s6_fault_ff <= s5_fault_ff | s6_x_in[16] | s6_y_in[16] | s6_z_in[32];
      s6_diff_ff  <= s6_diff_in;
   end

   // Stage 7: the two cross product terms.
   logic               s7_valid_ff;
   op_type             s7_op_ff;
   logic [15:0]        s7_sx_ff;
   logic [15:0]        s7_sy_ff;
   logic [31:0]        s7_sz_ff;
   logic               s7_fault_ff;
   logic [33:0]        s7_term_a_ff;
   logic [33:0]        s7_term_b_ff;
   logic [33:0]        s7_term_a_in;
   logic [33:0]        s7_term_b_in;

   always_comb begin
      s7_term_a_in = $signed(s6_diff_ff[0]) * $signed(s6_diff_ff[1]);
      s7_term_b_in = $signed(s6_diff_ff[2]) * $signed(s6_diff_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s7_op_ff     <= s6_op_ff;
      s7_sx_ff     <= s6_sx_ff;
      s7_sy_ff     <= s6_sy_ff;
      s7_sz_ff     <= s6_sz_ff;
      s7_fault_ff  <= s6_fault_ff;
      s7_term_a_ff <= s7_term_a_in;
      s7_term_b_ff <= s7_term_b_in;
   end

   // Final compare and result assembly.
   always_comb begin
      logic [34:0] cross_sum;
      cross_sum = 35'($signed(s7_term_a_ff)) - 35'($signed(s7_term_b_ff));
      out_push.valid = s7_valid_ff;
      if (s7_op_ff == OP_VERTEX) begin
         out_push.result.screen_x      = s7_sx_ff;
         out_push.result.screen_y      = s7_sy_ff;
         out_push.result.screen_z      = s7_sz_ff;
         out_push.result.range_fault   = s7_fault_ff;
         out_push.result.draw_triangle = 1'b0;
      end else begin
         out_push.result.screen_x      = '0;
         out_push.result.screen_y      = '0;
         out_push.result.screen_z      = '0;
         out_push.result.range_fault   = 1'b0;
         out_push.result.draw_triangle = !cross_sum[34];
      end
   end

endmodule

// ===== rtl/core/vtbc_out_queue.sv =====
module vtbc_out_queue import vtbc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              issue,
   input  result_push_type   push,
   vtbc_rsp_if.source        rsp,
   output logic              credit_ok
);

   localparam int OAW = $clog2(OUT_DEPTH);

   result_type     fifo_ff [OUT_DEPTH];
   logic [OAW-1:0] wr_ptr_ff;
   logic [OAW-1:0] rd_ptr_ff;
   logic [OAW:0]   count_ff;
   logic [OAW:0]   flight_ff;
   logic           pop;
   result_type     head;

   // An item may enter the back end only if its result is sure of a place here.
   assign credit_ok = ({1'b0, count_ff} + {1'b0, flight_ff}) < (OAW+2)'(OUT_DEPTH);

   assign head              = fifo_ff[rd_ptr_ff];
   assign rsp.valid         = count_ff != '0;
   assign rsp.screen_x      = head.screen_x;
   assign rsp.screen_y      = head.screen_y;
   assign rsp.screen_z      = head.screen_z;
   assign rsp.draw_triangle = head.draw_triangle;
   assign rsp.range_fault   = head.range_fault;
   assign pop               = rsp.valid && rsp.ready;

   // Result storage.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         fifo_ff[wr_ptr_ff] <= push.result;
      end
   end

   // Pointers, fill count and items still in the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         flight_ff <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push.valid && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push.valid) begin
            count_ff <= count_ff - 1'b1;
         end
         if (issue && !push.valid) begin
            flight_ff <= flight_ff + 1'b1;
         end else if (push.valid && !issue) begin
            flight_ff <= flight_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/core/vertex_transform_and_backface_cull.sv =====
// An accepted item passes the front queue, the back-end pipeline and the output
// queue in order; the 16-stage divider pipeline is most of the back end.
// Throughput: one item per cycle, vertex or triangle, sustained while results are taken.
// Up to 32 results are buffered; input stalls only when that buffer would fill.
// Reset is synchronous and active high: it clears the queues and pipeline valids
// and loads the register defaults. The vertex store is not cleared.
module vertex_transform_and_backface_cull import vtbc_pkg::*; #(
   parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   vtbc_req_if.sink   req_chan,
   vtbc_rsp_if.source rsp_chan,
   vtbc_csr_if.sink   csr_chan
);

   cfg_type         cfg_ff;
   logic            cmd_valid;
   cmd_type         cmd;
   logic            credit_ok;
   logic            issue;
   result_push_type push;

   // Register writes are always taken.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row         <= '0;
         cfg_ff.half_width  <= HALF_WIDTH_RST;
         cfg_ff.half_height <= HALF_HEIGHT_RST;
         cfg_ff.depth_scale <= DEPTH_SCALE_RST;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_ROW0: begin
               cfg_ff.row[0] <= csr_chan.data;
            end
            CSR_ROW1: begin
               cfg_ff.row[1] <= csr_chan.data;
            end
            CSR_ROW2: begin
               cfg_ff.row[2] <= csr_chan.data;
            end
            CSR_ROW3: begin
               cfg_ff.row[3] <= csr_chan.data;
            end
            CSR_HALF_WIDTH: begin
               cfg_ff.half_width <= csr_chan.data[12:0];
            end
            CSR_HALF_HEIGHT: begin
               cfg_ff.half_height <= csr_chan.data[12:0];
            end
            CSR_DEPTH_SCALE: begin
               cfg_ff.depth_scale <= csr_chan.data[30:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Items leave the front queue whenever the output side has room for them.
   assign issue = cmd_valid && credit_ok;

   vtbc_front #(
      .VERTEX_DEPTH(VERTEX_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (credit_ok)
   );

   vtbc_back #(
      .VERTEX_DEPTH(VERTEX_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (issue),
      .in_cmd   (cmd),
      .out_push (push)
   );

   vtbc_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .push      (push),
      .rsp       (rsp_chan),
      .credit_ok (credit_ok)
   );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import vtbc_pkg::*;

   localparam int HALF_PERIOD = 10;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT = 4000;
   localparam int STORE_DEPTH = 4096;
   localparam int RANDOM_PHASE_ITEMS = 350;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vtbc_req_if req_bus ();
   vtbc_rsp_if rsp_bus ();
   vtbc_csr_if csr_bus ();

   vertex_transform_and_backface_cull i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Shadow copy of the register file and the normalised vertex store.
   logic [3:0][63:0]   mat_rows;
   logic [12:0]        half_w;
   logic [12:0]        half_h;
   logic [30:0]        depth_mult;
   logic signed [15:0] ndc_x_mem [STORE_DEPTH];
   logic signed [15:0] ndc_y_mem [STORE_DEPTH];
   bit                 slot_written [STORE_DEPTH];
   int                 written_slots [$];

   result_type expected_results [$];
   int         errors = 0;
   int         rsp_hold = 0;
   bit         req_quiet = 1'b0;
   bit         rsp_quiet = 1'b0;
   int         idle_cycles = 0;

   always #(HALF_PERIOD) clock = ~clock;

   function automatic int draw_gap(bit quiet);
      return quiet ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic logic [63:0] pack_row(int c0, int c1, int c2, int c3);
      logic [15:0] a, b, c, d;
      a = c0[15:0];
      b = c1[15:0];
      c = c2[15:0];
      d = c3[15:0];
      return {d, c, b, a};
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi, inout bit flt);
      if (v < lo) begin
         flt = 1'b1;
         return lo;
      end
      if (v > hi) begin
         flt = 1'b1;
         return hi;
      end
      return v;
   endfunction

   // One row of the matrix applied to (x, y, z, 1); w is 1.0 in Q8.8.
   function automatic longint clip_coord(logic [63:0] row, longint x, longint y, longint z);
      longint c0, c1, c2, c3;
      c0 = longint'($signed(row[15:0]));
      c1 = longint'($signed(row[31:16]));
      c2 = longint'($signed(row[47:32]));
      c3 = longint'($signed(row[63:48]));
      return c0 * x + c1 * y + c2 * z + c3 * 256;
   endfunction

   // Perspective divide into Q2.14, rounding toward zero.
   function automatic longint divide_to_ndc(longint c, longint w, inout bit flt);
      longint mag, q;
      mag = (c < 0) ? -c : c;
      q = (mag << 14) / w;
      if (q > 65536) q = 65536;
      return clamp((c < 0) ? -q : q, -32768, 32767, flt);
   endfunction

   function automatic longint drop_frac14(longint v);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = mag >> 14;
      return (v < 0) ? -mag : mag;
   endfunction

   // Works out the result of one accepted item and updates the vertex store.
   function automatic result_type transform_or_cull(logic op, logic [11:0] slot,
         logic signed [15:0] px, logic signed [15:0] py, logic signed [15:0] pz,
         logic [11:0] ca, logic [11:0] cb, logic [11:0] cc);
      result_type r;
      bit         flt;
      longint     cx, cy, cz, cw, nx, ny, nz, hw, hh, cross_sum;
      longint     x0, y0, x1, y1, x2, y2;
      r = '0;
      flt = 1'b0;
      if (op == OP_VERTEX) begin
         cx = clip_coord(mat_rows[0], px, py, pz);
         cy = clip_coord(mat_rows[1], px, py, pz);
         cz = clip_coord(mat_rows[2], px, py, pz);
         cw = clip_coord(mat_rows[3], px, py, pz);
         nx = 0;
         ny = 0;
         nz = 0;
         if (cw <= 0) begin
            flt = 1'b1;
         end else begin
            nx = divide_to_ndc(cx, cw, flt);
            ny = divide_to_ndc(cy, cw, flt);
            nz = divide_to_ndc(cz, cw, flt);
         end
         ndc_x_mem[slot] = nx[15:0];
         ndc_y_mem[slot] = ny[15:0];
         hw = longint'(half_w);
         hh = longint'(half_h);
         r.screen_x = 16'(clamp(drop_frac14(hw * nx + hw * 16384), -32768, 32767, flt));
         r.screen_y = 16'(clamp(drop_frac14(hh * ny + hh * 16384), -32768, 32767, flt));
         r.screen_z = 32'(clamp(drop_frac14(longint'(depth_mult) * nz),
                                -64'sd2147483648, 64'sd2147483647, flt));
         r.range_fault = flt;
      end else begin
         x0 = longint'(ndc_x_mem[ca]);
         y0 = longint'(ndc_y_mem[ca]);
         x1 = longint'(ndc_x_mem[cb]);
         y1 = longint'(ndc_y_mem[cb]);
         x2 = longint'(ndc_x_mem[cc]);
         y2 = longint'(ndc_y_mem[cc]);
         cross_sum = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
         r.draw_triangle = (cross_sum >= 0);
      end
      return r;
   endfunction

   // Sends one item and records its expected result on the transfer.
   task automatic send_item(logic op, logic [11:0] slot, logic [15:0] px,
         logic [15:0] py, logic [15:0] pz, logic [11:0] ca, logic [11:0] cb,
         logic [11:0] cc);
      int gap;
      if ($urandom_range(0, 39) == 0) req_quiet = ~req_quiet;
      gap = draw_gap(req_quiet);
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.op          <= op;
      req_bus.vertex_slot <= slot;
      req_bus.pos_x       <= px;
      req_bus.pos_y       <= py;
      req_bus.pos_z       <= pz;
      req_bus.corner_a    <= ca;
      req_bus.corner_b    <= cb;
      req_bus.corner_c    <= cc;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(transform_or_cull(op, slot, px, py, pz, ca, cb, cc));
      if (op == OP_VERTEX && !slot_written[slot]) begin
         slot_written[slot] = 1'b1;
         written_slots.push_back(int'(slot));
      end
   endtask

   task automatic send_vertex(logic [11:0] slot, logic [15:0] px, logic [15:0] py,
         logic [15:0] pz);
      send_item(OP_VERTEX, slot, px, py, pz, 12'($urandom), 12'($urandom), 12'($urandom));
   endtask

   task automatic send_triangle(logic [11:0] ca, logic [11:0] cb, logic [11:0] cc);
      send_item(OP_TRIANGLE, 12'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), ca, cb, cc);
   endtask

   // Lowers valid and waits until every expected result has arrived.
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_ROW0:        mat_rows[0] = value;
         CSR_ROW1:        mat_rows[1] = value;
         CSR_ROW2:        mat_rows[2] = value;
         CSR_ROW3:        mat_rows[3] = value;
         CSR_HALF_WIDTH:  half_w = value[12:0];
         CSR_HALF_HEIGHT: half_h = value[12:0];
         CSR_DEPTH_SCALE: depth_mult = value[30:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic load_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
         logic [63:0] r3);
      write_reg(CSR_ROW0, r0);
      write_reg(CSR_ROW1, r1);
      write_reg(CSR_ROW2, r2);
      write_reg(CSR_ROW3, r3);
   endtask

   // Identity matrix with w of one, so ndc equals the model position.
   task automatic load_identity();
      load_matrix(pack_row(4096, 0, 0, 0), pack_row(0, 4096, 0, 0),
                  pack_row(0, 0, 4096, 0), pack_row(0, 0, 0, 4096));
   endtask

   task automatic load_viewport(int hw, int hh, int ds);
      write_reg(CSR_HALF_WIDTH, {$urandom, 19'($urandom), 13'(hw)});
      write_reg(CSR_HALF_HEIGHT, {$urandom, 19'($urandom), 13'(hh)});
      write_reg(CSR_DEPTH_SCALE, {$urandom, 1'($urandom), 31'(ds)});
   endtask

   // With the matrix at reset every vertex has w of zero and faults.
   task automatic test_reset_defaults();
      send_vertex(12'd0, 16'sd256, -16'sd256, 16'sd100);
      send_vertex(12'd1, 16'h7FFF, 16'h8000, 16'h0000);
      send_vertex(12'd2, 16'h0000, 16'h0000, 16'h0000);
      send_triangle(12'd0, 12'd1, 12'd2);
      wait_drained();
   endtask

   // Extremes of the fields, both windings, degenerate shapes and nonpositive w.
   task automatic test_directed_cases();
      load_identity();
      send_vertex(12'd0, 16'sd0, 16'sd0, 16'sd0);
      send_vertex(12'd4095, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_vertex(12'd4094, 16'h8000, 16'h8000, 16'h8000);
      send_vertex(12'd1, 16'sd128, 16'sd0, 16'sd64);
      send_vertex(12'd2, 16'sd0, 16'sd128, -16'sd64);
      send_vertex(12'd3, -16'sd511, -16'sd511, 16'sd511);
      send_triangle(12'd0, 12'd1, 12'd2);
      send_triangle(12'd0, 12'd2, 12'd1);
      send_triangle(12'd1, 12'd1, 12'd1);
      send_triangle(12'd4095, 12'd4094, 12'd0);
      send_triangle(12'd4094, 12'd4095, 12'd3);
      send_triangle(12'd0, 12'd4095, 12'd4095);
      wait_drained();
      // Negative w everywhere: ndc forced to zero and the fault raised.
      write_reg(CSR_ROW3, pack_row(0, 0, 0, -4096));
      send_vertex(12'd5, 16'sd200, -16'sd200, 16'sd50);
      send_vertex(12'd6, 16'h8000, 16'h7FFF, 16'h0001);
      send_triangle(12'd5, 12'd6, 12'd1);
      wait_drained();
      // w depends on z, so it crosses zero within one stream.
      write_reg(CSR_ROW3, pack_row(0, 0, 4096, 0));
      send_vertex(12'd7, 16'sd100, 16'sd100, 16'sd0);
      send_vertex(12'd8, 16'sd100, 16'sd100, -16'sd1);
      send_vertex(12'd9, 16'sd100, -16'sd100, 16'sd1);
      send_triangle(12'd7, 12'd8, 12'd9);
      wait_drained();
   endtask

   // Largest and smallest viewport and depth registers, extreme coefficients.
   task automatic test_register_extremes();
      load_matrix(pack_row(32767, -32768, 0, 0), pack_row(-32768, 0, 32767, 0),
                  pack_row(0, 0, 32767, 32767), pack_row(0, 0, 0, 32767));
      load_viewport(8191, 0, 32'h7FFFFFFF);
      send_vertex(12'd10, 16'h7FFF, 16'h8000, 16'h7FFF);
      send_vertex(12'd11, 16'sd1, 16'sd1, 16'sd1);
      send_vertex(12'd12, -16'sd300, 16'sd20, -16'sd40);
      send_triangle(12'd10, 12'd11, 12'd12);
      wait_drained();
      load_identity();
      load_viewport(0, 8191, 0);
      send_vertex(12'd13, 16'sd511, -16'sd511, 16'sd511);
      send_vertex(12'd14, -16'sd512, 16'sd512, -16'sd512);
      send_triangle(12'd13, 12'd14, 12'd0);
      wait_drained();
   endtask

   function automatic logic [15:0] random_pos();
      if ($urandom_range(0, 9) < 8) return 16'($urandom_range(0, 1200) - 600);
      return 16'($urandom);
   endfunction

   // Mostly vertices near the origin and triangles over stored slots.
   task automatic run_stream(int count);
      int n;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 55)
            send_vertex(12'($urandom), random_pos(), random_pos(), random_pos());
         else
            send_triangle(12'(written_slots[$urandom_range(0, written_slots.size() - 1)]),
                          12'(written_slots[$urandom_range(0, written_slots.size() - 1)]),
                          12'(written_slots[$urandom_range(0, written_slots.size() - 1)]));
      end
      wait_drained();
   endtask

   function automatic int small_coef(int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   // Several register settings, from sane projections to random noise.
   task automatic test_random_streams();
      int phase;
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               load_identity();
               load_viewport(320, 240, 100000000);
            end
            1, 2: begin
               load_matrix(pack_row(small_coef(8192), small_coef(8192), small_coef(8192),
                                    small_coef(8192)),
                           pack_row(small_coef(8192), small_coef(8192), small_coef(8192),
                                    small_coef(8192)),
                           pack_row(small_coef(8192), small_coef(8192), small_coef(8192),
                                    small_coef(8192)),
                           pack_row(small_coef(2048), small_coef(2048), small_coef(2048),
                                    $urandom_range(8192, 32767)));
               load_viewport($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom);
            end
            default: begin
               load_matrix({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom});
               load_viewport($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom);
            end
         endcase
         run_stream(RANDOM_PHASE_ITEMS);
      end
   endtask

   // Result side: random back-pressure driven at the falling edge.
   always @(negedge clock) begin
      if (!reset && rsp_hold == 0) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= 1'b0;
         if (rsp_hold > 0) rsp_hold = rsp_hold - 1;
      end
   end

   // Compares each result transfer with the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if ($urandom_range(0, 39) == 0) rsp_quiet = ~rsp_quiet;
         rsp_hold = draw_gap(rsp_quiet);
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, x %0d y %0d z %0d", $time,
                     rsp_bus.screen_x, rsp_bus.screen_y, rsp_bus.screen_z);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.screen_x !== want.screen_x) begin
               errors++;
               $display("%0t: screen_x expected %0d actual %0d", $time,
                        $signed(want.screen_x), rsp_bus.screen_x);
            end
            if (rsp_bus.screen_y !== want.screen_y) begin
               errors++;
               $display("%0t: screen_y expected %0d actual %0d", $time,
                        $signed(want.screen_y), rsp_bus.screen_y);
            end
            if (rsp_bus.screen_z !== want.screen_z) begin
               errors++;
               $display("%0t: screen_z expected %0d actual %0d", $time,
                        $signed(want.screen_z), rsp_bus.screen_z);
            end
            if (rsp_bus.draw_triangle !== want.draw_triangle) begin
               errors++;
               $display("%0t: draw_triangle expected %0b actual %0b", $time,
                        want.draw_triangle, rsp_bus.draw_triangle);
            end
            if (rsp_bus.range_fault !== want.range_fault) begin
               errors++;
               $display("%0t: range_fault expected %0b actual %0b", $time,
                        want.range_fault, rsp_bus.range_fault);
            end
         end
      end
   end

   // Watchdog over cycles in which no transfer happens on any channel.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.op          = OP_VERTEX;
      req_bus.vertex_slot = '0;
      req_bus.pos_x       = '0;
      req_bus.pos_y       = '0;
      req_bus.pos_z       = '0;
      req_bus.corner_a    = '0;
      req_bus.corner_b    = '0;
      req_bus.corner_c    = '0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_ROW0;
      csr_bus.data        = '0;
      mat_rows            = '0;
      half_w              = HALF_WIDTH_RST;
      half_h              = HALF_HEIGHT_RST;
      depth_mult          = DEPTH_SCALE_RST;
      foreach (ndc_x_mem[i]) begin
         ndc_x_mem[i] = '0;
         ndc_y_mem[i] = '0;
         slot_written[i] = 1'b0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_cases();
      test_register_extremes();
      test_random_streams();

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/vtbc_pkg.sv
rtl/core/vtbc_channels.sv
rtl/core/vtbc_front.sv
rtl/core/vtbc_back.sv
rtl/core/vtbc_out_queue.sv
rtl/core/vertex_transform_and_backface_cull.sv
test/tb.sv
